>>> src/dpod_pkg.sv
// shared types, constants and calendar tables for the date period overlap block
package dpod_pkg;

   localparam int unsigned DAY_W       = 5;
   localparam int unsigned MON_W       = 4;
   localparam int unsigned YEAR_W      = 14;
   localparam int unsigned NUM_W       = 23;
   localparam int unsigned CNT_W       = 22;
   localparam int unsigned OFF_W       = 9;
   localparam int unsigned PIPE_DEPTH  = 5;

   localparam logic [YEAR_W-1:0] MAX_YEAR    = YEAR_W'(9999);
   localparam logic [CNT_W-1:0]  OVERLAP_MAX = {CNT_W{1'b1}};

   // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 43690
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
   localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
   localparam int unsigned QY_W        = 8;
   localparam int unsigned Q4_W        = YEAR_W - 2;
   localparam int unsigned Q400_W      = 6;

   localparam logic [MON_W-1:0] MONTH_FEB = MON_W'(2);

   typedef struct packed {
      logic [DAY_W-1:0]  a_start_day;
      logic [MON_W-1:0]  a_start_month;
      logic [YEAR_W-1:0] a_start_year;
      logic [DAY_W-1:0]  a_end_day;
      logic [MON_W-1:0]  a_end_month;
      logic [YEAR_W-1:0] a_end_year;
      logic [DAY_W-1:0]  b_start_day;
      logic [MON_W-1:0]  b_start_month;
      logic [YEAR_W-1:0] b_start_year;
      logic [DAY_W-1:0]  b_end_day;
      logic [MON_W-1:0]  b_end_month;
      logic [YEAR_W-1:0] b_end_year;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] overlap_days;
      logic             bad_date;
   } rsp_type;

   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [MON_W-1:0]  month;
      logic [YEAR_W-1:0] year;
   } date_type;

   // stage load enables of the date converter
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } conv_en_type;

   // stage load enables of the compare section
   typedef struct packed {
      logic s4;
      logic s5;
   } cmp_en_type;

   // length of a month in a common year, zero for a month code out of range
   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
         4'd2:                                       len = DAY_W'(28);
         default:                                    len = '0;
      endcase
      return len;
   endfunction

   // days of a common year before the first of the month
   function automatic logic [OFF_W-1:0] month_start(input logic [MON_W-1:0] m);
      logic [OFF_W-1:0] off;
      case (m)
         4'd2:    off = OFF_W'(31);
         4'd3:    off = OFF_W'(59);
         4'd4:    off = OFF_W'(90);
         4'd5:    off = OFF_W'(120);
         4'd6:    off = OFF_W'(151);
         4'd7:    off = OFF_W'(181);
         4'd8:    off = OFF_W'(212);
         4'd9:    off = OFF_W'(243);
         4'd10:   off = OFF_W'(273);
         4'd11:   off = OFF_W'(304);
         4'd12:   off = OFF_W'(334);
         default: off = '0;
      endcase
      return off;
   endfunction

endpackage

>>> src/dpod_day_num.sv
// three-stage conversion of one calendar date to its day number, with validity check
module dpod_day_num
   import dpod_pkg::*;
(
   input  logic             clock,
   input  conv_en_type      en,
   input  date_type         date_in,
   output logic [NUM_W-1:0] num,
   output logic             ok
);

   // stage 1: reciprocal multiplications for the century terms
   logic [PROD_W-1:0] prod_y_in;
   logic [PROD_W-1:0] prod_p_in;
   logic [YEAR_W-1:0] p_in;
   logic [Q4_W-1:0]   q4_in;

   logic [DAY_W-1:0]  day_s1_ff;
   logic [MON_W-1:0]  month_s1_ff;
   logic [YEAR_W-1:0] year_s1_ff;
   logic [YEAR_W-1:0] p_s1_ff;
   logic [Q4_W-1:0]   q4_s1_ff;
   logic [QY_W-1:0]   qy_s1_ff;
   logic [Q400_W-1:0] q400_s1_ff;

   assign p_in      = date_in.year - YEAR_W'(1);
   assign q4_in     = p_in[YEAR_W-1:2];
   assign prod_y_in = PROD_W'(date_in.year) * PROD_W'(RECIP_100);
   assign prod_p_in = PROD_W'(q4_in) * PROD_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         day_s1_ff   <= date_in.day;
         month_s1_ff <= date_in.month;
         year_s1_ff  <= date_in.year;
         p_s1_ff     <= p_in;
         q4_s1_ff    <= q4_in;
         qy_s1_ff    <= prod_y_in[RECIP_SHIFT +: QY_W];
         q400_s1_ff  <= prod_p_in[RECIP_SHIFT +: Q400_W];
      end
   end

   // stage 2: leap rule, month checks and the whole-year term
   logic              c100_in;
   logic              leap_in;
   logic [DAY_W-1:0]  dim_in;
   logic              valid_in;
   logic [OFF_W-1:0]  off_in;

   logic [NUM_W-1:0]  base_s2_ff;
   logic [Q4_W-1:0]   q4_s2_ff;
   logic [QY_W-1:0]   q100_s2_ff;
   logic [Q400_W-1:0] q400_s2_ff;
   logic [OFF_W-1:0]  off_s2_ff;
   logic [DAY_W-1:0]  day_s2_ff;
   logic              ok_s2_ff;

   always_comb begin
      c100_in  = (YEAR_W'(qy_s1_ff) * YEAR_W'(100)) == year_s1_ff;
      leap_in  = (year_s1_ff[1:0] == 2'b00) && (!c100_in || (qy_s1_ff[1:0] == 2'b00));
      dim_in   = month_len(month_s1_ff)
               + DAY_W'((month_s1_ff == MONTH_FEB) && leap_in);
      valid_in = (year_s1_ff != '0) && (year_s1_ff <= MAX_YEAR)
               && (day_s1_ff != '0) && (day_s1_ff <= dim_in);
      off_in   = month_start(month_s1_ff)
               + OFF_W'(leap_in && (month_s1_ff > MONTH_FEB));
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         base_s2_ff <= NUM_W'(p_s1_ff) * NUM_W'(365);
         q4_s2_ff   <= q4_s1_ff;
         // p / 100 is one less than year / 100 when the year is a century
         q100_s2_ff <= qy_s1_ff - QY_W'(c100_in);
         q400_s2_ff <= q400_s1_ff;
         off_s2_ff  <= off_in;
         day_s2_ff  <= day_s1_ff;
         ok_s2_ff   <= valid_in;
      end
   end

   // stage 3: sum of the day number terms
   logic [NUM_W-1:0] num_s3_ff;
   logic             ok_s3_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         num_s3_ff <= base_s2_ff + NUM_W'(q4_s2_ff) - NUM_W'(q100_s2_ff)
                    + NUM_W'(q400_s2_ff) + NUM_W'(off_s2_ff) + NUM_W'(day_s2_ff);
         ok_s3_ff  <= ok_s2_ff;
      end
   end

   assign num = num_s3_ff;
   assign ok  = ok_s3_ff;

endmodule

>>> src/dpod_overlap.sv
// two-stage intersection of the periods and clamped day count
module dpod_overlap
   import dpod_pkg::*;
(
   input  logic             clock,
   input  cmp_en_type       en,
   input  logic [NUM_W-1:0] a_start,
   input  logic [NUM_W-1:0] a_end,
   input  logic [NUM_W-1:0] b_start,
   input  logic [NUM_W-1:0] b_end,
   input  logic [3:0]       date_ok,
   output rsp_type          rsp
);

   // stage 4: later start and earlier end
   logic [NUM_W-1:0] lo_s4_ff;
   logic [NUM_W-1:0] hi_s4_ff;
   logic             ok_s4_ff;

   always_ff @(posedge clock) begin
      if (en.s4) begin
         lo_s4_ff <= (a_start > b_start) ? a_start : b_start;
         hi_s4_ff <= (a_end < b_end) ? a_end : b_end;
         ok_s4_ff <= &date_ok;
      end
   end

   // stage 5: inclusive length, zero when empty or a date is bad
   logic [NUM_W-1:0] span_in;
   logic [CNT_W-1:0] cnt_in;
   rsp_type          rsp_s5_ff;

   always_comb begin
      span_in = hi_s4_ff - lo_s4_ff + NUM_W'(1);
      if (!ok_s4_ff || (hi_s4_ff < lo_s4_ff)) begin
         cnt_in = '0;
      end else if (span_in > NUM_W'(OVERLAP_MAX)) begin
         cnt_in = OVERLAP_MAX;
      end else begin
         cnt_in = span_in[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         rsp_s5_ff.overlap_days <= cnt_in;
         rsp_s5_ff.bad_date     <= !ok_s4_ff;
      end
   end

   assign rsp = rsp_s5_ff;

endmodule

>>> src/date_period_overlap_days.sv
// top level: date period overlap in days, pipeline control and the four date converters
//
// Takes two Gregorian periods (start and end date each) and returns the number of
// calendar days both share, both ends counted, or zero with bad_date set when any
// date is invalid. A new transfer is taken every cycle while req_stall is low, and
// each request passes three stages of date to day number conversion, then a stage
// of intersection and one of clamped count. Every stage
// holds its own valid bit and loads whenever the stage after it can move, so bubbles
// close up under back-pressure and the output register keeps a finished result while
// earlier stages go on filling.
module date_period_overlap_days
   import dpod_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [PIPE_DEPTH:1] vld_ff;
   logic [PIPE_DEPTH:1] vld_in;
   logic [PIPE_DEPTH:1] en;

   // a stage loads when it is empty or its item moves on
   always_comb begin
      en[PIPE_DEPTH] = !vld_ff[PIPE_DEPTH] || !rsp_stall;
      for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[1] = en[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = vld_ff[PIPE_DEPTH];

   conv_en_type conv_en;
   cmp_en_type  cmp_en;

   assign conv_en = '{s1: en[1], s2: en[2], s3: en[3]};
   assign cmp_en  = '{s4: en[4], s5: en[5]};

   // day numbers of the four dates
   date_type         date_as, date_ae, date_bs, date_be;
   logic [NUM_W-1:0] num_as, num_ae, num_bs, num_be;
   logic [3:0]       date_ok;

   assign date_as = '{day: req_data.a_start_day, month: req_data.a_start_month,
                      year: req_data.a_start_year};
   assign date_ae = '{day: req_data.a_end_day, month: req_data.a_end_month,
                      year: req_data.a_end_year};
   assign date_bs = '{day: req_data.b_start_day, month: req_data.b_start_month,
                      year: req_data.b_start_year};
   assign date_be = '{day: req_data.b_end_day, month: req_data.b_end_month,
                      year: req_data.b_end_year};

   dpod_day_num u_conv_as (
      .clock   (clock),
      .en      (conv_en),
      .date_in (date_as),
      .num     (num_as),
      .ok      (date_ok[0])
   );

   dpod_day_num u_conv_ae (
      .clock   (clock),
      .en      (conv_en),
      .date_in (date_ae),
      .num     (num_ae),
      .ok      (date_ok[1])
   );

   dpod_day_num u_conv_bs (
      .clock   (clock),
      .en      (conv_en),
      .date_in (date_bs),
      .num     (num_bs),
      .ok      (date_ok[2])
   );

   dpod_day_num u_conv_be (
      .clock   (clock),
      .en      (conv_en),
      .date_in (date_be),
      .num     (num_be),
      .ok      (date_ok[3])
   );

   // intersection and count
   dpod_overlap u_overlap (
      .clock   (clock),
      .en      (cmp_en),
      .a_start (num_as),
      .a_end   (num_ae),
      .b_start (num_bs),
      .b_end   (num_be),
      .date_ok (date_ok),
      .rsp     (rsp_data)
   );

   // a bad date never reports a count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_date |-> rsp_data.overlap_days == '0)
      else $error("count reported with a bad date");

   // an accepted transfer occupies the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[1])
      else $error("accepted request lost at stage one");

   // a full pipeline behind a held result pushes back on the request side
   assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && rsp_stall |-> req_stall)
      else $error("full pipeline took a request");

   // a held result stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("held result dropped");

endmodule

>>> tb/sv/date_period_overlap_days_test.sv
// testbench for date_period_overlap_days: directed and random period pairs against a day-count predictor
`timescale 1ns / 1ps

module date_period_overlap_days_test;
   import dpod_pkg::*;

   localparam int unsigned MAX_GAP     = 40;
   localparam int unsigned HOLD_CYCLES = 120;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // overlap counts still owed by the block, oldest first
   rsp_type expected_overlaps [$];
   int      mismatches    = 0;
   int      req_idle_pct  = 0;
   int      rsp_stall_pct = 0;
   int      hold_requests = 0;
   int      hold_served   = 0;
   int      hold_left     = 0;

   date_period_overlap_days dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // calendar arithmetic

   function automatic bit leap_year(int unsigned year);
      return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
   endfunction

   function automatic int unsigned month_days(int unsigned year, int unsigned month);
      case (month)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year(year) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // day number with 0001-01-01 as day 1, zero for an invalid date
   function automatic int unsigned date_serial(date_type d);
      int unsigned year, prior, num, month;
      year = d.year;
      if (year < 1 || year > MAX_YEAR) return 0;
      if (d.day < 1 || d.day > month_days(year, d.month)) return 0;
      prior = year - 1;
      num   = prior * 365 + prior / 4 - prior / 100 + prior / 400 + d.day;
      for (month = 1; month < d.month; month++) num += month_days(year, month);
      return num;
   endfunction

   // shared days of the two periods, both ends counted
   function automatic rsp_type overlap_of(req_type q);
      date_type [3:0] span;
      int unsigned    a_from, a_to, b_from, b_to, lo, hi, cnt;
      rsp_type        r;
      span   = q;
      a_from = date_serial(span[3]);
      a_to   = date_serial(span[2]);
      b_from = date_serial(span[1]);
      b_to   = date_serial(span[0]);
      cnt    = 0;
      r.bad_date = (a_from == 0) || (a_to == 0) || (b_from == 0) || (b_to == 0);
      if (!r.bad_date) begin
         lo = (a_from > b_from) ? a_from : b_from;
         hi = (a_to < b_to) ? a_to : b_to;
         if (hi >= lo) cnt = hi - lo + 1;
         if (cnt > OVERLAP_MAX) cnt = OVERLAP_MAX;
      end
      r.overlap_days = CNT_W'(cnt);
      return r;
   endfunction

   // query construction

   function automatic date_type calendar_date(int unsigned year, int unsigned month,
                                              int unsigned day);
      date_type d;
      d.day   = DAY_W'(day);
      d.month = MON_W'(month);
      d.year  = YEAR_W'(year);
      return d;
   endfunction

   // puts each period in order unless a reversed one is wanted
   function automatic req_type span_query(date_type a_from, date_type a_to,
                                          date_type b_from, date_type b_to,
                                          bit keep_order);
      date_type swap;
      if (!keep_order && date_serial(a_from) > date_serial(a_to)) begin
         swap = a_from; a_from = a_to; a_to = swap;
      end
      if (!keep_order && date_serial(b_from) > date_serial(b_to)) begin
         swap = b_from; b_from = b_to; b_to = swap;
      end
      return {a_from, a_to, b_from, b_to};
   endfunction

   // years near the ends of the range and on centuries turn up often
   function automatic int unsigned pick_year();
      case ($urandom_range(7))
         0:       return $urandom_range(4, 1);
         1:       return $urandom_range(MAX_YEAR, MAX_YEAR - 3);
         2:       return 100 * $urandom_range(99, 1);
         default: return $urandom_range(MAX_YEAR, 1);
      endcase
   endfunction

   function automatic date_type valid_date(int unsigned year_lo, int unsigned year_hi);
      date_type d;
      d.year  = YEAR_W'($urandom_range(year_hi, year_lo));
      d.month = MON_W'($urandom_range(12, 1));
      if ($urandom_range(3) == 0) d.day = DAY_W'(month_days(d.year, d.month));
      else d.day = DAY_W'($urandom_range(month_days(d.year, d.month), 1));
      return d;
   endfunction

   // mostly well-formed periods close together, some wide, some shared, some corrupted
   function automatic req_type random_query();
      date_type    d [4];
      logic [31:0] raw;
      int unsigned base, top, kind, sel, i;
      kind = $urandom_range(99);
      base = pick_year();
      top  = (base < MAX_YEAR) ? base + 1 : base;
      for (i = 0; i < 4; i++) d[i] = valid_date(base, top);
      if (kind >= 55 && kind < 70) begin
         for (i = 0; i < 4; i++) d[i] = valid_date(1, MAX_YEAR);
      end else if (kind >= 70 && kind < 80) begin
         d[2] = d[0];
         d[3] = d[1];
      end else if (kind >= 80) begin
         sel = $urandom_range(3);
         if (kind < 90) begin
            raw    = $urandom;
            d[sel] = raw[$bits(date_type)-1:0];
         end else begin
            d[sel].day = DAY_W'(month_days(d[sel].year, d[sel].month) + 1);
         end
      end
      return span_query(d[0], d[1], d[2], d[3], $urandom_range(19) == 0);
   endfunction

   // stimulus side

   task automatic offer_query(input req_type q);
      int gap;
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      expected_overlaps.push_back(overlap_of(q));
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < req_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic await_overlaps();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_overlaps.size() != 0);
   endtask

   // receiver: long hold when asked, random stalls otherwise
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_overlaps.size() == 0) begin
            $error("overlap_days: unexpected result, actual %0d bad_date %0b",
                   rsp_data.overlap_days, rsp_data.bad_date);
            mismatches++;
         end else begin
            want = expected_overlaps.pop_front();
            if (rsp_data.overlap_days !== want.overlap_days) begin
               $error("overlap_days: expected %0d, actual %0d",
                      want.overlap_days, rsp_data.overlap_days);
               mismatches++;
            end
            if (rsp_data.bad_date !== want.bad_date) begin
               $error("bad_date: expected %0b, actual %0b", want.bad_date, rsp_data.bad_date);
               mismatches++;
            end
         end
      end
   end

   // tests

   task automatic test_span_extremes();
      date_type first_day, last_day;
      first_day = calendar_date(1, 1, 1);
      last_day  = calendar_date(9999, 12, 31);
      offer_query(span_query(first_day, first_day, first_day, first_day, 1'b1));
      offer_query(span_query(first_day, last_day, first_day, last_day, 1'b1));
      offer_query(span_query(first_day, last_day, last_day, last_day, 1'b1));
      // adjacent months, no shared day
      offer_query(span_query(calendar_date(2000, 1, 1), calendar_date(2000, 1, 31),
                             calendar_date(2000, 2, 1), calendar_date(2000, 2, 29), 1'b1));
      // periods touching on one day across a year boundary
      offer_query(span_query(calendar_date(1999, 12, 31), calendar_date(2000, 1, 1),
                             calendar_date(2000, 1, 1), calendar_date(2000, 3, 1), 1'b1));
      // short period inside a long one
      offer_query(span_query(calendar_date(1600, 1, 1), calendar_date(2400, 12, 31),
                             calendar_date(1900, 2, 28), calendar_date(1900, 3, 1), 1'b1));
      await_overlaps();
   endtask

   task automatic test_leap_rule();
      date_type jan, dec;
      jan = calendar_date(1800, 1, 1);
      dec = calendar_date(2500, 12, 31);
      offer_query(span_query(calendar_date(2000, 2, 28), calendar_date(2000, 3, 1),
                             calendar_date(2000, 2, 28), calendar_date(2000, 3, 1), 1'b1));
      offer_query(span_query(calendar_date(1900, 2, 29), dec, jan, dec, 1'b1));
      offer_query(span_query(jan, calendar_date(2024, 2, 29), jan, dec, 1'b1));
      offer_query(span_query(jan, dec, calendar_date(2023, 2, 29), dec, 1'b1));
      offer_query(span_query(calendar_date(400, 2, 29), dec, calendar_date(1, 1, 1),
                             calendar_date(400, 3, 1), 1'b1));
      await_overlaps();
   endtask

   task automatic test_invalid_dates();
      date_type lo, hi;
      lo = calendar_date(2010, 1, 1);
      hi = calendar_date(2010, 12, 31);
      // day zero, day past the end of April, month zero, month thirteen
      offer_query(span_query(calendar_date(2010, 3, 0), hi, lo, hi, 1'b1));
      offer_query(span_query(lo, calendar_date(2010, 4, 31), lo, hi, 1'b1));
      offer_query(span_query(lo, hi, calendar_date(2010, 0, 5), hi, 1'b1));
      offer_query(span_query(lo, hi, lo, calendar_date(2010, 13, 5), 1'b1));
      // year zero and the first year past the range
      offer_query(span_query(calendar_date(0, 6, 1), hi, lo, hi, 1'b1));
      offer_query(span_query(lo, hi, lo, calendar_date(10000, 1, 1), 1'b1));
      // every field all ones, then all zeros
      offer_query('1);
      offer_query('0);
      await_overlaps();
   endtask

   task automatic test_reversed_period();
      date_type lo, hi;
      lo = calendar_date(2020, 1, 1);
      hi = calendar_date(2020, 12, 31);
      offer_query(span_query(calendar_date(2020, 5, 10), calendar_date(2020, 5, 1),
                             lo, hi, 1'b1));
      offer_query(span_query(hi, lo, hi, lo, 1'b1));
      await_overlaps();
   endtask

   task automatic test_random_traffic(int unsigned count, int idle_pct, int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) offer_query(random_query());
      await_overlaps();
   endtask

   // receiver holds off while the sender keeps offering, so the pipeline fills
   task automatic test_output_hold();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_requests++;
      repeat (40) offer_query(random_query());
      await_overlaps();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_span_extremes();
      test_leap_rule();
      test_invalid_dates();
      test_reversed_period();
      test_random_traffic(300, 0, 0);
      test_random_traffic(300, 68, 0);
      test_random_traffic(300, 0, 68);
      test_random_traffic(300, 36, 36);
      test_output_hold();
      rsp_stall_pct = 0;
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (mismatches == 0) $display("date_period_overlap_days verification clean");
      else $display("date_period_overlap_days verification failed");
      $finish;
   end

   // run limit
   initial begin
      #1_000_000;
      $display("date_period_overlap_days verification failed");
      $finish;
   end

endmodule

>>> filelist.f
src/dpod_pkg.sv
src/dpod_day_num.sv
src/dpod_overlap.sv
src/date_period_overlap_days.sv
tb/sv/date_period_overlap_days_test.sv
